>>> sv/wvd_pkg.sv
// package for the weighted vector distance unit
// widths, metric codes and shared controller/datapath command types; no dependencies
package wvd_pkg;

  localparam int COORD_BITS = 16;
  localparam int ACC_BITS   = 48;
  localparam int W_BITS     = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int Q_BITS     = DIFF_BITS + 16;
  localparam int DIV_STEPS  = Q_BITS;
  localparam int CNT_BITS   = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] MODE_SQ  = 2'd0;
  localparam logic [1:0] MODE_MAN = 2'd1;
  localparam logic [1:0] MODE_CHB = 2'd2;
  localparam logic [1:0] MODE_REL = 2'd3;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul1;
    logic mul2;
    logic mul3;
    logic accum;
    logic clear;
  } wvd_cmd_t;

  typedef struct packed {
    logic div_done;
  } wvd_stat_t;

endpackage

>>> sv/weighted_vector_distance_top.sv
// weighted vector distance top: config register, controller and datapath
// depends on wvd_pkg, wvd_ctrl, wvd_datapath
// per item: load, divide in relative mode only (33-step divider), multiplies, accumulate
// one item at a time: a new item is taken only while the controller is idle, plus result handshake on the last item
// reset: synchronous; clears mode, accumulator, flags and controller
module weighted_vector_distance_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [wvd_pkg::COORD_BITS-1:0] coord_a,
  input  logic signed [wvd_pkg::COORD_BITS-1:0] coord_b,
  input  logic [wvd_pkg::W_BITS-1:0] weight,
  input  logic        last_dim,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [wvd_pkg::ACC_BITS-1:0] dist_value,
  output logic        saturated,
  output logic        div_by_zero
);
  logic [1:0] metric_mode;
  wvd_pkg::wvd_cmd_t  cmd;
  wvd_pkg::wvd_stat_t stat;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) metric_mode <= wvd_pkg::MODE_SQ;
    else if (cfg_valid) metric_mode <= cfg_data;
  end

  wvd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .last_dim, .metric_mode,
    .out_valid, .out_ready, .cmd, .stat
  );

  wvd_datapath u_dp (
    .clk, .rst, .cmd, .stat, .metric_mode, .coord_a, .coord_b, .weight,
    .acc_value(dist_value), .sat_flag(saturated), .dz_flag(div_by_zero)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_dz_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_by_zero |-> saturated) else $error("divide by zero without saturation");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dist_value))
    else $error("result changed while stalled");
endmodule

>>> sv/wvd_datapath.sv
// datapath: operand registers, restoring divider, sequenced multiplies, accumulator
// depends on wvd_pkg
module wvd_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  wvd_pkg::wvd_cmd_t              cmd,
  output wvd_pkg::wvd_stat_t             stat,
  input  logic [1:0]                     metric_mode,
  input  logic signed [wvd_pkg::COORD_BITS-1:0] coord_a,
  input  logic signed [wvd_pkg::COORD_BITS-1:0] coord_b,
  input  logic [wvd_pkg::W_BITS-1:0]     weight,
  output logic [wvd_pkg::ACC_BITS-1:0]   acc_value,
  output logic                           sat_flag,
  output logic                           dz_flag
);
  localparam int DB = wvd_pkg::DIFF_BITS;
  localparam int QB = wvd_pkg::Q_BITS;
  localparam int AB = wvd_pkg::ACC_BITS;
  localparam int CB = wvd_pkg::CNT_BITS;
  localparam int PB = 2 * QB + wvd_pkg::W_BITS;

  logic [1:0]      mode;
  logic [DB-1:0]   ad;
  logic [DB-1:0]   am;
  logic            a_zero;
  logic [wvd_pkg::W_BITS-1:0] w;
  logic [QB-1:0]   quo;
  logic [DB:0]     rem;
  logic [QB-1:0]   dividend;
  logic [CB-1:0]   cnt;
  logic [2*QB-1:0] sq;
  logic [PB-1:0]   prod;
  logic [AB-1:0]   term;
  logic            term_sat;
  logic [AB-1:0]   acc;
  logic            sat_s;
  logic            dz_s;

  logic signed [DB-1:0] diff;
  logic [DB:0]     rem_sh;
  logic [DB:0]     rem_sub;
  logic [QB-1:0]   x_op;
  logic [PB-1:0]   scaled;
  logic [5:0]      shamt;
  logic [AB:0]     sum;

  assign diff = DB'(coord_a) - DB'(coord_b);
  assign rem_sh  = {rem[DB-1:0], dividend[QB-1]};
  assign rem_sub = rem_sh - {1'b0, am};
  assign stat.div_done = (cnt == CB'(wvd_pkg::DIV_STEPS));
  assign x_op = (mode == wvd_pkg::MODE_REL) ? quo : QB'(ad);

  always_comb begin
    case (mode)
      wvd_pkg::MODE_SQ:  shamt = 6'd14;
      wvd_pkg::MODE_REL: shamt = 6'd30;
      default:           shamt = 6'd6;
    endcase
    scaled = prod >> shamt;
  end

  assign sum = {1'b0, acc} + {1'b0, term};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0; sat_s <= 1'b0; dz_s <= 1'b0; cnt <= '0;
    end else begin
      if (cmd.load) begin
        mode     <= metric_mode;
        ad       <= diff[DB-1] ? DB'(-diff) : DB'(diff);
        am       <= coord_a[wvd_pkg::COORD_BITS-1] ? DB'(-DB'(coord_a)) : DB'(coord_a);
        a_zero   <= (coord_a == '0);
        w        <= weight;
        cnt      <= '0;
        rem      <= '0;
        quo      <= '0;
        dividend <= {(diff[DB-1] ? DB'(-diff) : DB'(diff)), 16'd0};
      end
      if (cmd.div_step) begin
        if (!rem_sub[DB]) begin
          rem <= rem_sub; quo <= {quo[QB-2:0], 1'b1};
        end else begin
          rem <= rem_sh; quo <= {quo[QB-2:0], 1'b0};
        end
        dividend <= dividend << 1;
        cnt <= cnt + 1'b1;
      end
      if (cmd.mul1) sq <= (mode == wvd_pkg::MODE_SQ || mode == wvd_pkg::MODE_REL)
                          ? x_op * x_op : (2*QB)'(x_op);
      if (cmd.mul2) prod <= sq * w;
      if (cmd.mul3) begin
        if (mode == wvd_pkg::MODE_REL && a_zero) begin
          term <= '1; term_sat <= 1'b1; dz_s <= 1'b1;
        end else if (scaled[PB-1:AB] != '0) begin
          term <= '1; term_sat <= 1'b1;
        end else begin
          term <= scaled[AB-1:0]; term_sat <= 1'b0;
        end
      end
      if (cmd.accum) begin
        sat_s <= sat_s | term_sat | ((mode != wvd_pkg::MODE_CHB) && sum[AB]);
        if (mode == wvd_pkg::MODE_CHB) begin
          if (term > acc) acc <= term;
        end else if (sum[AB]) begin
          acc <= '1;
        end else begin
          acc <= sum[AB-1:0];
        end
      end
      if (cmd.clear) begin
        acc <= '0; sat_s <= 1'b0; dz_s <= 1'b0;
      end
    end
  end

  assign acc_value = acc;
  assign sat_flag  = sat_s;
  assign dz_flag   = dz_s;
endmodule

>>> sv/wvd_ctrl.sv
// controller state machine sequencing divide, multiplies, accumulate and result
// depends on wvd_pkg
module wvd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               last_dim,
  input  logic [1:0]         metric_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output wvd_pkg::wvd_cmd_t  cmd,
  input  wvd_pkg::wvd_stat_t stat
);
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL1, S_MUL2, S_MUL3, S_ACC, S_OUT} state_t;
  state_t state;
  logic   last;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.div_step = (state == S_DIV) && !stat.div_done;
    cmd.mul1     = (state == S_MUL1);
    cmd.mul2     = (state == S_MUL2);
    cmd.mul3     = (state == S_MUL3);
    cmd.accum    = (state == S_ACC);
    cmd.clear    = (state == S_OUT) && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; last <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          last  <= last_dim;
          state <= (metric_mode == wvd_pkg::MODE_REL) ? S_DIV : S_MUL1;
        end
        S_DIV:  if (stat.div_done) state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_MUL3;
        S_MUL3: state <= S_ACC;
        S_ACC:  state <= last ? S_OUT : S_IDLE;
        S_OUT:  if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
